// ----- rtl/core/sha256_pkg.sv -----
// shared types, request codes, round constants and mixing functions for the sha-256 hasher
// depends on nothing; imported by sha256_stream_hasher_top and tb
`default_nettype none

package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] window_t;

    localparam logic REQ_ABSORB = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic word_t rotr(word_t x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sha256_stream_hasher_top.sv -----
// byte-stream sha-256 hasher: block window, one shared round unit, digest output
// depends on sha256_pkg
`default_nettype none

// Absorb transactions take one byte per cycle while the hasher is idle; the 64th
// byte of a block starts the compression, which runs one round per cycle through
// a single shared round unit, then an update step folds the working words into
// the hash. A finish transaction pads one byte per cycle up to the block end,
// compresses, repeats both once more when 56 or more bytes were buffered, then
// offers the eight digest words, one per output transaction, word 0 first.
// in_stall is high throughout this work.

module sha256_stream_hasher_top
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PAD      = 3'd1;
    localparam logic [2:0] ST_COMPRESS = 3'd2;
    localparam logic [2:0] ST_UPDATE   = 3'd3;
    localparam logic [2:0] ST_OUT      = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] msg_bits_reg, msg_bits_next;
    logic [63:0] len_reg, len_next;
    logic        extra_reg, extra_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_mode_reg, pad_mode_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    word_t       hash_reg [8];
    word_t       hash_next [8];
    word_t       v_reg [8];
    word_t       v_next [8];
    window_t     w_reg, w_next;

    logic        in_fire;
    logic        out_fire;
    logic        len_phase;
    logic [7:0]  pad_byte;
    word_t       t1, t2, w_new;

    assign in_fire   = in_valid && (state_reg == ST_IDLE);
    assign out_fire  = (state_reg == ST_OUT) && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign digest_word = hash_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    // length bytes fill the last eight slots of the final padded block
    assign len_phase = !extra_reg && (fill_reg[5:3] == 3'b111);
    assign pad_byte  = pad_first_reg ? PAD_MARK : (len_phase ? len_reg[63:56] : 8'h00);

    // shared round unit; w_reg[15] is the oldest schedule word
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_reg] + w_reg[15];
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = w_reg[15] + small_sigma0(w_reg[14]) + w_reg[6] + small_sigma1(w_reg[1]);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        msg_bits_next  = msg_bits_reg;
        len_next       = len_reg;
        extra_next     = extra_reg;
        pad_first_next = pad_first_reg;
        pad_mode_next  = pad_mode_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        hash_next      = hash_reg;
        v_next         = v_reg;
        w_next         = w_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == REQ_ABSORB)
                    begin
                        w_next        = {w_reg[15][23:0], w_reg[14:0], data_byte};
                        fill_next     = fill_reg + 6'd1;
                        pad_mode_next = 1'b0;
                        if (&fill_reg)
                        begin
                            msg_bits_next = msg_bits_reg + 64'd512;
                            v_next        = hash_reg;
                            round_next    = '0;
                            state_next    = ST_COMPRESS;
                        end
                    end
                    else
                    begin
                        len_next       = msg_bits_reg + {55'd0, fill_reg, 3'b000};
                        extra_next     = (fill_reg[5:3] == 3'b111);
                        pad_first_next = 1'b1;
                        pad_mode_next  = 1'b1;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                w_next         = {w_reg[15][23:0], w_reg[14:0], pad_byte};
                fill_next      = fill_reg + 6'd1;
                pad_first_next = 1'b0;
                if (len_phase)
                begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                if (&fill_reg)
                begin
                    v_next     = hash_reg;
                    round_next = '0;
                    state_next = ST_COMPRESS;
                end
            end
            ST_COMPRESS:
            begin
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
                w_next     = {w_reg[14:0], w_new};
                round_next = round_reg + 6'd1;
                if (&round_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                if (!pad_mode_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (extra_reg)
                begin
                    // first padded block done, the length goes in a second one
                    extra_next = 1'b0;
                    state_next = ST_PAD;
                end
                else
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        hash_next     = INIT_H;
                        fill_next     = '0;
                        msg_bits_next = '0;
                        pad_mode_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            msg_bits_reg  <= '0;
            extra_reg     <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_mode_reg  <= 1'b0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            hash_reg      <= INIT_H;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            msg_bits_reg  <= msg_bits_next;
            extra_reg     <= extra_next;
            pad_first_reg <= pad_first_next;
            pad_mode_reg  <= pad_mode_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            hash_reg      <= hash_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        v_reg   <= v_next;
        w_reg   <= w_next;
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// self-checking testbench for sha256_stream_hasher_top: random byte streams and finishes
// predicts each digest with its own sha-256 model and checks every output word
// depends on sha256_pkg and rtl/core/sha256_stream_hasher_top.sv

module tb
    import sha256_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 90;
    localparam int LEN_SLACK     = 40;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic       kind;
        logic [7:0] value;
    } hash_req_t;

    typedef struct {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    hash_req_t    pending_reqs [$];
    digest_beat_t expected_words [$];

    // predictor state
    word_t       hash_state [8];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill_bytes;
    logic [63:0] completed_bits;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_armed = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int reqs_accepted = 0;
    int messages_hashed = 0;
    int words_checked = 0;
    int mismatches = 0;
    int boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    sha256_stream_hasher_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic word_t rotate_right(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void start_message();
        for (int k = 0; k < 8; k++)
            hash_state[k] = HASH_INIT[k];
        fill_bytes = '0;
        completed_bits = '0;
    endfunction

    function void compress_block_bytes();
        word_t w [64];
        word_t a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (rotate_right(w[t-15], 7) ^ rotate_right(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotate_right(w[t-2], 17) ^ rotate_right(w[t-2], 19) ^ (w[t-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (rotate_right(e, 6) ^ rotate_right(e, 11) ^ rotate_right(e, 25))
               + ((e & f) ^ (~e & g)) + RK[t] + w[t];
            t2 = (rotate_right(a, 2) ^ rotate_right(a, 13) ^ rotate_right(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    // absorb stores a byte and compresses a full block, finish pads, compresses and queues the eight digest words
    function void hash_transaction(logic kind, logic [7:0] value);
        logic [63:0]  total;
        int           pos;
        digest_beat_t beat;
        if (kind == REQ_ABSORB)
        begin
            block_bytes[fill_bytes] = value;
            fill_bytes = fill_bytes + 6'd1;
            if (fill_bytes == 6'd0)
            begin
                compress_block_bytes();
                completed_bits = completed_bits + 64'd512;
            end
        end
        else
        begin
            pos = int'(fill_bytes);
            total = completed_bits + 64'(pos) * 64'd8;
            block_bytes[pos] = 8'h80;
            pos = pos + 1;
            // no room for the length: close this block and start an all-padding one
            if (pos > 56)
            begin
                for (int k = pos; k < 64; k++)
                    block_bytes[k] = 8'h00;
                compress_block_bytes();
                pos = 0;
            end
            for (int k = pos; k < 56; k++)
                block_bytes[k] = 8'h00;
            for (int k = 0; k < 8; k++)
                block_bytes[56+k] = total[63-8*k -: 8];
            compress_block_bytes();
            for (int k = 0; k < 8; k++)
            begin
                beat.word = hash_state[k];
                beat.idx  = 3'(k);
                beat.last = (k == 7);
                expected_words.push_back(beat);
            end
            messages_hashed++;
            start_message();
        end
    endfunction

    // driver: offers queued requests, predicts on every accepted transaction
    always @(posedge clk)
    begin : drive_requests
        hash_req_t next_req;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                hash_transaction(req_type, data_byte);
                reqs_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= next_req.kind;
                    data_byte <= next_req.value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks digest words and drives the output stall
    always @(posedge clk)
    begin : check_digest
        digest_beat_t exp_beat;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected digest word %08h index %0d", digest_word, word_index);
                    mismatches++;
                end
                else
                begin
                    exp_beat = expected_words.pop_front();
                    if (digest_word !== exp_beat.word)
                    begin
                        $error("digest_word: expected %08h, got %08h", exp_beat.word, digest_word);
                        mismatches++;
                    end
                    if (word_index !== exp_beat.idx)
                    begin
                        $error("word_index: expected %0d, got %0d", exp_beat.idx, word_index);
                        mismatches++;
                    end
                    if (last_word !== exp_beat.last)
                    begin
                        $error("last_word: expected %0b, got %0b", exp_beat.last, last_word);
                        mismatches++;
                    end
                end
            end
            // one long hold-off so the hasher backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_armed && out_valid)
            begin
                hold_armed = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("** sha256_stream_hasher_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic push_req(logic kind, logic [7:0] value);
        hash_req_t r;
        r.kind = kind;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(12);
        else if (r < 80)
            return boundary_lens[$urandom_range(9)];
        else
            return $urandom_range(200, 66);
    endfunction

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int len;
        int phase_items;
        int room;
        start_message();
        for (int k = 0; k < 64; k++)
            block_bytes[k] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 49;

        // directed: empty message twice, "abc", byte extremes, lone pad-like byte
        push_req(REQ_FINISH, 8'hff);
        push_req(REQ_FINISH, 8'h00);
        push_req(REQ_ABSORB, 8'h61);
        push_req(REQ_ABSORB, 8'h62);
        push_req(REQ_ABSORB, 8'h63);
        push_req(REQ_FINISH, 8'h5a);
        push_req(REQ_ABSORB, 8'h00);
        push_req(REQ_ABSORB, 8'hff);
        push_req(REQ_FINISH, 8'hff);
        push_req(REQ_ABSORB, 8'h80);
        push_req(REQ_FINISH, 8'h00);
        wait_quiet();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 49 : 0;
            recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 35 : 0;
            if (phase == 2)
                hold_armed = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                len = pick_length();
                // keep each phase near its budget; long messages still fit early on
                room = PHASE_ITEMS - phase_items + LEN_SLACK;
                if (len > room)
                    len = room;
                for (int k = 0; k < len; k++)
                    push_req(REQ_ABSORB, 8'($urandom_range(255)));
                push_req(REQ_FINISH, 8'($urandom_range(255)));
                phase_items += len + 1;
            end
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d digest words never arrived", expected_words.size());
            mismatches++;
        end
        $display("run covered %0d transactions in, %0d messages hashed, %0d digest words checked",
                 reqs_accepted, messages_hashed, words_checked);
        $display("lengths around the 55/56 and 64-byte block edges, three idle mixes, long hold-off");
        if (mismatches == 0)
            $display("** sha256_stream_hasher_top: PASSED **");
        else
            $display("** sha256_stream_hasher_top: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sha256_pkg.sv
rtl/core/sha256_stream_hasher_top.sv
sim/tb.sv
